/* rtl/core/ptp_pkg.sv */
// Shared types, codes and constant tables of the partition table parser.
package ptp_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MBR,
		PH_HDR,
		PH_ARR
	} phase_t;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_FAIL  = 2'd2;

	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_NAME   = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic [1:0] SCHEME_NONE = 2'd0;
	localparam logic [1:0] SCHEME_MBR  = 2'd1;
	localparam logic [1:0] SCHEME_GPT  = 2'd2;

	localparam int NSLOT     = 6;
	localparam int SLOT_PRIM = 0;
	localparam int SLOT_TAIL = 5;

	localparam logic [8:0] MBR_TABLE_START = 9'h1BE;
	localparam logic [8:0] MBR_TABLE_END   = 9'h1FE;
	localparam logic [8:0] SIG_LOW_OFS     = 9'd510;
	localparam logic [8:0] LAST_OFS        = 9'd511;
	localparam logic [7:0] SIG_LOW         = 8'h55;
	localparam logic [7:0] SIG_HIGH        = 8'hAA;
	localparam logic [7:0] TYPE_PROTECTIVE = 8'hEE;

	localparam logic [8:0] HDR_SIG_LEN    = 9'd8;
	localparam logic [8:0] HDR_ARRAY_OFS  = 9'd72;
	localparam logic [8:0] HDR_TOTAL_OFS  = 9'd80;
	localparam logic [8:0] HDR_SIZE_OFS   = 9'd84;
	localparam logic [8:0] HDR_SIZE_END   = 9'd88;

	localparam logic [9:0] GUID_END   = 10'd16;
	localparam logic [9:0] START_OFS  = 10'd32;
	localparam logic [9:0] END_OFS    = 10'd40;
	localparam logic [9:0] END_LAST   = 10'd47;
	localparam logic [9:0] END_END    = 10'd48;
	localparam logic [9:0] NAME_START = 10'd56;
	localparam logic [9:0] NAME_END   = 10'd128;

	localparam logic [31:0] ENTRY_MIN = 32'd128;
	localparam logic [31:0] ENTRY_MAX = 32'd512;
	localparam logic [6:0]  CHAR_SUB  = 7'h3F;

	localparam logic [7:0] KNOWN_GUID [6][16] = '{
		'{8'h28,8'h73,8'h2A,8'hC1,8'h1F,8'hF8,8'hD2,8'h11,
		  8'hBA,8'h4B,8'h00,8'hA0,8'hC9,8'h3E,8'hC9,8'h3B},
		'{8'hA2,8'hA0,8'hD0,8'hEB,8'hE5,8'hB9,8'h33,8'h44,
		  8'h87,8'hC0,8'h68,8'hB6,8'hB7,8'h26,8'h99,8'hC7},
		'{8'h16,8'hE3,8'hC9,8'hE3,8'h5C,8'h0B,8'hB8,8'h4D,
		  8'h81,8'h7D,8'hF9,8'h2D,8'hF0,8'h02,8'h15,8'hAE},
		'{8'hAF,8'h3D,8'hC6,8'h0F,8'h83,8'h84,8'h72,8'h47,
		  8'h8E,8'h79,8'h3D,8'h69,8'hD8,8'h47,8'h7D,8'hE4},
		'{8'h6D,8'hFD,8'h57,8'h06,8'hAB,8'hA4,8'hC4,8'h43,
		  8'h84,8'hE5,8'h09,8'h33,8'hC8,8'h4B,8'h4F,8'h4F},
		'{8'h00,8'h53,8'h46,8'h48,8'h00,8'h00,8'hAA,8'h11,
		  8'hAA,8'h11,8'h00,8'h30,8'h65,8'h43,8'hEC,8'hAC}
	};

	localparam logic [7:0] HDR_SIG [8] = '{
		8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  scheme;
		logic [3:0]  part_index;
		logic [63:0] read_lba;
		logic [63:0] part_first;
		logic [63:0] part_size;
		logic [7:0]  legacy_type;
		logic [2:0]  gpt_type;
		logic [6:0]  name_char;
	} item_t;

	function automatic item_t make_item(input logic [1:0] kind, input logic [1:0] scheme,
			input logic [3:0] idx, input logic [63:0] lba, input logic [63:0] ls,
			input logic [63:0] lc, input logic [7:0] mt, input logic [2:0] gt,
			input logic [6:0] ch);
		item_t r;
		r.kind        = kind;
		r.scheme      = scheme;
		r.part_index  = idx;
		r.read_lba    = lba;
		r.part_first  = ls;
		r.part_size   = lc;
		r.legacy_type = mt;
		r.gpt_type    = gt;
		r.name_char   = ch;
		return r;
	endfunction

endpackage

/* rtl/core/ptp_core.sv */
// Scan state and per-item decoding of sector bytes into a bundle of results.
module ptp_core #(
	parameter int MAX_PARTITIONS = 16,
	parameter int NAME_CAP       = 36
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          command,
	input  logic [1:0]          drive,
	input  logic [7:0]          data_byte,
	output ptp_pkg::item_t      slots [ptp_pkg::NSLOT],
	output logic [ptp_pkg::NSLOT-1:0] pend,
	output logic [1:0]          bundle_drive
);

	localparam int FW = $clog2(MAX_PARTITIONS + 1);

	ptp_pkg::phase_t phase_q, n_phase;
	logic [1:0]  drive_q, n_drive;
	logic [8:0]  offset_q, n_offset;
	logic [7:0]  mtype_q  [4];
	logic [31:0] mstart_q [4];
	logic [31:0] mcount_q [4];
	logic        prot_q, n_prot, hdr_ok_q, n_hdr_ok, sig_low_q, n_sig_low;
	logic [63:0] array_lba_q, n_array_lba;
	logic [31:0] total_q, n_total, size_q, n_size;
	logic [9:0]  ebytes_q, n_ebytes, pos_q, n_pos;
	logic [2:0]  per_q, n_per, num_q, n_num;
	logic [31:0] sread_q, n_sread;
	logic [33:0] base_q, n_base;
	logic [FW-1:0] found_q, n_found;
	logic [3:0]  slot_q, n_slot;
	logic        gaz_q, n_gaz, nend_q, n_nend;
	logic [5:0]  gm_q, n_gm, nlen_q, n_nlen;
	logic [63:0] start_q, n_start, end_q, n_end;
	logic [7:0]  low_q, n_low;

	logic        mbr_wr;
	logic [1:0]  mbr_e;
	logic [3:0]  mbr_f;
	logic [8:0]  mo;
	logic        do_report, in_use;
	logic [FW-1:0] cnt;
	logic [2:0]  gt;
	logic [15:0] code;
	logic [33:0] nb;

	always_comb begin
		n_phase = phase_q; n_drive = drive_q; n_offset = offset_q;
		n_prot = prot_q; n_hdr_ok = hdr_ok_q; n_sig_low = sig_low_q;
		n_array_lba = array_lba_q; n_total = total_q; n_size = size_q;
		n_ebytes = ebytes_q; n_pos = pos_q; n_per = per_q; n_num = num_q;
		n_sread = sread_q; n_base = base_q; n_found = found_q; n_slot = slot_q;
		n_gaz = gaz_q; n_nend = nend_q; n_gm = gm_q; n_nlen = nlen_q;
		n_start = start_q; n_end = end_q; n_low = low_q;
		for (int i = 0; i < ptp_pkg::NSLOT; i++) begin
			slots[i] = '0;
		end
		pend = '0;
		mbr_wr = 1'b0;
		mo = offset_q - ptp_pkg::MBR_TABLE_START;
		mbr_e = mo[5:4];
		mbr_f = mo[3:0];
		do_report = 1'b0;
		in_use = 1'b0;
		cnt = '0;
		gt = '0;
		code = '0;
		nb = '0;

		if (accept) begin
			case (command)
				ptp_pkg::CMD_START: begin
					n_drive = drive; n_phase = ptp_pkg::PH_MBR; n_offset = '0;
					n_sig_low = 1'b0; n_prot = 1'b0; n_found = '0;
					slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(ptp_pkg::KIND_READ,
						ptp_pkg::SCHEME_NONE, '0, '0, '0, '0, '0, '0, '0);
					pend[ptp_pkg::SLOT_TAIL] = 1'b1;
				end
				ptp_pkg::CMD_BYTE: begin
					if (phase_q != ptp_pkg::PH_IDLE) begin
						n_offset = offset_q + 9'd1;
						case (phase_q)
							ptp_pkg::PH_MBR: begin
								if (offset_q >= ptp_pkg::MBR_TABLE_START &&
										offset_q < ptp_pkg::MBR_TABLE_END) begin
									mbr_wr = 1'b1;
									if (mbr_f == 4'd4 && data_byte == ptp_pkg::TYPE_PROTECTIVE)
										n_prot = 1'b1;
								end else if (offset_q == ptp_pkg::SIG_LOW_OFS) begin
									n_sig_low = (data_byte == ptp_pkg::SIG_LOW);
								end else if (offset_q == ptp_pkg::LAST_OFS) begin
									if (!(sig_low_q && data_byte == ptp_pkg::SIG_HIGH)) begin
										slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(
											ptp_pkg::KIND_DONE, ptp_pkg::SCHEME_NONE,
											'0, '0, '0, '0, '0, '0, '0);
										pend[ptp_pkg::SLOT_TAIL] = 1'b1;
										n_phase = ptp_pkg::PH_IDLE;
									end else if (prot_q) begin
										n_phase = ptp_pkg::PH_HDR; n_hdr_ok = 1'b1;
										n_array_lba = '0; n_total = '0; n_size = '0;
										slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(
											ptp_pkg::KIND_READ, ptp_pkg::SCHEME_NONE,
											'0, 64'd1, '0, '0, '0, '0, '0);
										pend[ptp_pkg::SLOT_TAIL] = 1'b1;
									end else begin
										do_report = 1'b1;
									end
								end
							end
							ptp_pkg::PH_HDR: begin
								if (offset_q < ptp_pkg::HDR_SIG_LEN) begin
									if (data_byte != ptp_pkg::HDR_SIG[offset_q[2:0]])
										n_hdr_ok = 1'b0;
								end else if (offset_q >= ptp_pkg::HDR_ARRAY_OFS &&
										offset_q < ptp_pkg::HDR_TOTAL_OFS) begin
									if (offset_q[2:0] == 3'd0) n_array_lba = {56'd0, data_byte};
									else n_array_lba[offset_q[2:0]*8 +: 8] = data_byte;
								end else if (offset_q >= ptp_pkg::HDR_TOTAL_OFS &&
										offset_q < ptp_pkg::HDR_SIZE_OFS) begin
									if (offset_q[1:0] == 2'd0) n_total = {24'd0, data_byte};
									else n_total[offset_q[1:0]*8 +: 8] = data_byte;
								end else if (offset_q >= ptp_pkg::HDR_SIZE_OFS &&
										offset_q < ptp_pkg::HDR_SIZE_END) begin
									if (offset_q[1:0] == 2'd0) n_size = {24'd0, data_byte};
									else n_size[offset_q[1:0]*8 +: 8] = data_byte;
								end else if (offset_q == ptp_pkg::LAST_OFS) begin
									if (hdr_ok_q && size_q >= ptp_pkg::ENTRY_MIN &&
											size_q <= ptp_pkg::ENTRY_MAX) begin
										n_ebytes = size_q[9:0]; n_sread = '0;
										n_found = '0; n_base = '0;
										if (size_q == 32'd128) n_per = 3'd4;
										else if (size_q <= 32'd170) n_per = 3'd3;
										else if (size_q <= 32'd256) n_per = 3'd2;
										else n_per = 3'd1;
										if (total_q == '0) begin
											slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(
												ptp_pkg::KIND_DONE, ptp_pkg::SCHEME_GPT,
												'0, '0, '0, '0, '0, '0, '0);
											n_phase = ptp_pkg::PH_IDLE;
										end else begin
											n_phase = ptp_pkg::PH_ARR; n_pos = '0; n_num = '0;
											slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(
												ptp_pkg::KIND_READ, ptp_pkg::SCHEME_NONE,
												'0, array_lba_q, '0, '0, '0, '0, '0);
										end
										pend[ptp_pkg::SLOT_TAIL] = 1'b1;
									end else begin
										do_report = 1'b1;
									end
								end
							end
							default: begin
								in_use = (num_q < per_q) &&
									(({1'b0, base_q} + 35'(num_q)) < 35'(total_q));
								if (in_use) begin
									if (pos_q == '0) begin
										n_gaz = 1'b1; n_gm = 6'h3F; n_nlen = '0;
										n_nend = 1'b0; n_start = '0; n_end = '0;
									end
									if (pos_q < ptp_pkg::GUID_END) begin
										if (data_byte != 8'd0) n_gaz = 1'b0;
										for (int t = 0; t < 6; t++) begin
											if (data_byte != ptp_pkg::KNOWN_GUID[t][pos_q[3:0]])
												n_gm[t] = 1'b0;
										end
									end else if (pos_q >= ptp_pkg::START_OFS &&
											pos_q < ptp_pkg::END_OFS) begin
										if (pos_q[2:0] == 3'd0) n_start = {56'd0, data_byte};
										else n_start[pos_q[2:0]*8 +: 8] = data_byte;
									end else if (pos_q >= ptp_pkg::END_OFS &&
											pos_q < ptp_pkg::END_END) begin
										if (pos_q[2:0] == 3'd0) n_end = {56'd0, data_byte};
										else n_end[pos_q[2:0]*8 +: 8] = data_byte;
										if (pos_q == ptp_pkg::END_LAST) begin
											if (n_gaz || found_q >= FW'(MAX_PARTITIONS)) begin
												n_nend = 1'b1;
											end else begin
												for (int t = 5; t >= 0; t--) begin
													if (n_gm[t]) gt = 3'(t + 1);
												end
												n_slot = 4'(found_q);
												slots[ptp_pkg::SLOT_PRIM] = ptp_pkg::make_item(
													ptp_pkg::KIND_RECORD, ptp_pkg::SCHEME_GPT,
													4'(found_q), '0, n_start,
													n_end - n_start + 64'd1, '0, gt, '0);
												pend[ptp_pkg::SLOT_PRIM] = 1'b1;
												n_found = found_q + FW'(1);
											end
										end
									end else if (pos_q >= ptp_pkg::NAME_START &&
											pos_q < ptp_pkg::NAME_END) begin
										if (!pos_q[0]) begin
											n_low = data_byte;
										end else if (!n_nend) begin
											code = {data_byte, low_q};
											if (code == '0 ||
													(7'(n_nlen) + 7'd1) >= 7'(NAME_CAP)) begin
												n_nend = 1'b1;
											end else begin
												slots[ptp_pkg::SLOT_PRIM] = ptp_pkg::make_item(
													ptp_pkg::KIND_NAME, ptp_pkg::SCHEME_NONE,
													slot_q, '0, '0, '0, '0, '0,
													(code < 16'h80) ? code[6:0] : ptp_pkg::CHAR_SUB);
												pend[ptp_pkg::SLOT_PRIM] = 1'b1;
												n_nlen = n_nlen + 6'd1;
											end
										end
									end
								end
								if ((pos_q + 10'd1) >= ebytes_q) begin
									n_pos = '0; n_num = num_q + 3'd1;
								end else begin
									n_pos = pos_q + 10'd1;
								end
								if (offset_q == ptp_pkg::LAST_OFS) begin
									n_sread = sread_q + 32'd1;
									nb = base_q + 34'(per_q);
									n_base = nb;
									if (nb < 34'(total_q) && n_found < FW'(MAX_PARTITIONS)) begin
										n_pos = '0; n_num = '0;
										slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(
											ptp_pkg::KIND_READ, ptp_pkg::SCHEME_NONE, '0,
											array_lba_q + 64'(n_sread), '0, '0, '0, '0, '0);
									end else begin
										slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(
											ptp_pkg::KIND_DONE, ptp_pkg::SCHEME_GPT,
											'0, '0, '0, '0, '0, '0, '0);
										n_phase = ptp_pkg::PH_IDLE;
									end
									pend[ptp_pkg::SLOT_TAIL] = 1'b1;
								end
							end
						endcase
					end
				end
				ptp_pkg::CMD_FAIL: begin
					if (phase_q != ptp_pkg::PH_IDLE) begin
						n_offset = '0;
						case (phase_q)
							ptp_pkg::PH_HDR: do_report = 1'b1;
							default: begin
								slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(ptp_pkg::KIND_DONE,
									(phase_q == ptp_pkg::PH_MBR) ? ptp_pkg::SCHEME_NONE :
									ptp_pkg::SCHEME_GPT, '0, '0, '0, '0, '0, '0, '0);
								pend[ptp_pkg::SLOT_TAIL] = 1'b1;
								n_phase = ptp_pkg::PH_IDLE;
							end
						endcase
					end
				end
				default: ;
			endcase

			if (do_report) begin
				cnt = found_q;
				for (int i = 0; i < 4; i++) begin
					if (mtype_q[i] != 8'd0 && mcount_q[i] != 32'd0 &&
							cnt < FW'(MAX_PARTITIONS)) begin
						slots[1 + i] = ptp_pkg::make_item(ptp_pkg::KIND_RECORD,
							ptp_pkg::SCHEME_MBR, 4'(cnt), '0, {32'd0, mstart_q[i]},
							{32'd0, mcount_q[i]}, mtype_q[i], '0, '0);
						pend[1 + i] = 1'b1;
						cnt = cnt + FW'(1);
					end
				end
				n_found = cnt;
				slots[ptp_pkg::SLOT_TAIL] = ptp_pkg::make_item(ptp_pkg::KIND_DONE,
					ptp_pkg::SCHEME_MBR, '0, '0, '0, '0, '0, '0, '0);
				pend[ptp_pkg::SLOT_TAIL] = 1'b1;
				n_phase = ptp_pkg::PH_IDLE;
			end
		end
	end

	assign bundle_drive = n_drive;

	always_ff @(posedge clk) begin
		if (mbr_wr) begin
			if (mbr_f == 4'd4) begin
				mtype_q[mbr_e] <= data_byte;
			end else if (mbr_f >= 4'd8 && mbr_f < 4'd12) begin
				if (mbr_f[1:0] == 2'd0) mstart_q[mbr_e] <= {24'd0, data_byte};
				else mstart_q[mbr_e][mbr_f[1:0]*8 +: 8] <= data_byte;
			end else if (mbr_f >= 4'd12) begin
				if (mbr_f[1:0] == 2'd0) mcount_q[mbr_e] <= {24'd0, data_byte};
				else mcount_q[mbr_e][mbr_f[1:0]*8 +: 8] <= data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ptp_pkg::PH_IDLE; drive_q <= '0; offset_q <= '0;
			prot_q <= 1'b0; hdr_ok_q <= 1'b0; sig_low_q <= 1'b0;
			array_lba_q <= '0; total_q <= '0; size_q <= '0;
			ebytes_q <= '0; pos_q <= '0; per_q <= '0; num_q <= '0;
			sread_q <= '0; base_q <= '0; found_q <= '0; slot_q <= '0;
			gaz_q <= 1'b1; nend_q <= 1'b0; gm_q <= 6'h3F; nlen_q <= '0;
			start_q <= '0; end_q <= '0; low_q <= '0;
		end else begin
			phase_q <= n_phase; drive_q <= n_drive; offset_q <= n_offset;
			prot_q <= n_prot; hdr_ok_q <= n_hdr_ok; sig_low_q <= n_sig_low;
			array_lba_q <= n_array_lba; total_q <= n_total; size_q <= n_size;
			ebytes_q <= n_ebytes; pos_q <= n_pos; per_q <= n_per; num_q <= n_num;
			sread_q <= n_sread; base_q <= n_base; found_q <= n_found; slot_q <= n_slot;
			gaz_q <= n_gaz; nend_q <= n_nend; gm_q <= n_gm; nlen_q <= n_nlen;
			start_q <= n_start; end_q <= n_end; low_q <= n_low;
		end
	end

endmodule

/* rtl/core/ptp_emit.sv */
// Result bundle register and output register that hand out one result item per cycle while m_tready is high.
module ptp_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ptp_pkg::item_t      slots_in [ptp_pkg::NSLOT],
	input  logic [ptp_pkg::NSLOT-1:0] pend_in,
	input  logic [1:0]          drive_in,
	output logic                free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [223:0]        m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);

	ptp_pkg::item_t slots_q [ptp_pkg::NSLOT];
	logic [ptp_pkg::NSLOT-1:0] pend_q, rest;
	logic [1:0]  drive_q, out_drive_q;
	logic [2:0]  pick;
	logic        take;
	ptp_pkg::item_t out_q;
	logic        valid_q, last_q;

	always_comb begin
		pick = '0;
		for (int i = ptp_pkg::NSLOT - 1; i >= 0; i--) begin
			if (pend_q[i]) pick = 3'(i);
		end
		rest = pend_q & ~(ptp_pkg::NSLOT'(1) << pick);
		take = (pend_q != '0) && (!valid_q || m_tready);
		free = (pend_q == '0) || (take && rest == '0);
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			slots_q <= slots_in;
			drive_q <= drive_in;
		end
		if (take) begin
			out_q       <= slots_q[pick];
			last_q      <= (rest == '0);
			out_drive_q <= drive_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load && free) pend_q <= pend_in;
			else if (take) pend_q <= rest;
			if (take) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {6'd0, out_q.name_char, out_q.gpt_type, out_q.legacy_type,
		out_q.part_size, out_q.part_first, out_q.part_index, out_q.scheme,
		out_q.read_lba, out_drive_q};

endmodule

/* rtl/core/partition_table_parser.sv */
// Top level of the partition table parser: input decoding and result output.
// Each input item is decoded in the cycle it is accepted and its results are
// registered as a bundle, which the output register hands out one item per
// cycle while m_tready is high. The input is held until the last item of the
// bundle is taken, so after items that cause at most one result (nearly every
// sector byte) a new item can be accepted every cycle while m_tready is high.
// Largest is the MBR report: up to four partition records and the done item.
module partition_table_parser #(
	parameter int MAX_PARTITIONS = 16,
	parameter int NAME_CAP       = 36
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // drive [1:0], data_byte [9:2], zero padding
	input  logic [1:0]   s_tuser,  // command [1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// read_drive [1:0], read_lba [65:2], scheme [67:66], part_index [71:68],
	// part_first [135:72], part_size [199:136], legacy_type [207:200],
	// gpt_type [210:208], name_char [217:211], zero padding
	output logic [223:0] m_tdata,
	output logic [1:0]   m_tuser,  // kind [1:0]
	output logic         m_tlast
);

	ptp_pkg::item_t slots [ptp_pkg::NSLOT];
	logic [ptp_pkg::NSLOT-1:0] pend;
	logic [1:0] bundle_drive;
	logic       free;
	logic       accept;

	assign s_tready = free;
	assign accept   = s_tvalid && free;

	ptp_core #(
		.MAX_PARTITIONS(MAX_PARTITIONS),
		.NAME_CAP(NAME_CAP)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.command(s_tuser),
		.drive(s_tdata[1:0]),
		.data_byte(s_tdata[9:2]),
		.slots(slots),
		.pend(pend),
		.bundle_drive(bundle_drive)
	);

	ptp_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.slots_in(slots),
		.pend_in(pend),
		.drive_in(bundle_drive),
		.free(free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

/* test/tb.sv */
// Self-checking testbench of the partition table parser, with its own scan predictor.
module tb;
	import ptp_pkg::*;

	localparam int MAX_PART = 16;
	localparam int NAME_LIMIT = 36;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic        last;
		logic [1:0]  drv;
		logic [63:0] lba;
		logic [1:0]  scheme;
		logic [3:0]  idx;
		logic [63:0] ls;
		logic [63:0] lc;
		logic [7:0]  mt;
		logic [2:0]  gt;
		logic [6:0]  ch;
	} scan_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [223:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	partition_table_parser #(.MAX_PARTITIONS(MAX_PART), .NAME_CAP(NAME_LIMIT)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int err_count = 0;
	int results_checked = 0;
	int scans_run = 0;
	bit steady = 1'b0;
	logic [7:0] sec [512];
	int gsel_plan [$];
	bit mbr_extreme = 1'b0;

	scan_result_t pending_results [$];
	scan_result_t step_results [$];

	// Predicted state of the scanner.
	phase_t      ph;
	logic [1:0]  sdrv;
	logic [8:0]  boff;
	logic [7:0]  mtype [4];
	logic [31:0] mstart [4];
	logic [31:0] mcount [4];
	bit          prot, hdr_good, sig_low_seen, gzero, nend;
	logic [63:0] arr_lba, st_sec, en_sec;
	logic [31:0] etotal, ebytes, sreads, size_fld, ent_num;
	int          epos, found, cur_slot, nlen;
	logic [5:0]  gmatch;
	logic [7:0]  lowb;

	function automatic void emit(logic [1:0] kind, logic [63:0] lba, logic [1:0] scheme,
			int idx, logic [63:0] ls, logic [63:0] lc, logic [7:0] mt, logic [2:0] gt,
			logic [6:0] ch);
		scan_result_t r;
		r.kind = kind; r.last = 1'b0; r.drv = sdrv; r.lba = lba; r.scheme = scheme;
		r.idx = idx[3:0]; r.ls = ls; r.lc = lc; r.mt = mt; r.gt = gt; r.ch = ch;
		step_results.push_back(r);
	endfunction

	function automatic void report_mbr_entries();
		for (int i = 0; i < 4; i++) begin
			if (mtype[i] != 0 && mcount[i] != 0 && found < MAX_PART) begin
				emit(KIND_RECORD, 0, SCHEME_MBR, found, 64'(mstart[i]), 64'(mcount[i]),
					mtype[i], 0, 0);
				found++;
			end
		end
		emit(KIND_DONE, 0, SCHEME_MBR, 0, 0, 0, 0, 0, 0);
		ph = PH_IDLE;
	endfunction

	function automatic void entry_byte(int p, logic [7:0] b);
		logic [15:0] c;
		logic [2:0] gt;
		if (p == 0) begin
			gzero = 1'b1; gmatch = '1; nlen = 0; nend = 1'b0; st_sec = 0; en_sec = 0;
		end
		if (p < 16) begin
			if (b != 0) gzero = 1'b0;
			for (int t = 0; t < 6; t++)
				if (b != KNOWN_GUID[t][p]) gmatch[t] = 1'b0;
		end else if (p >= 32 && p < 40) begin
			st_sec[8*(p-32) +: 8] = b;
		end else if (p >= 40 && p < 48) begin
			en_sec[8*(p-40) +: 8] = b;
			if (p == 47) begin
				if (gzero || found >= MAX_PART) begin
					nend = 1'b1;
				end else begin
					gt = 0;
					for (int t = 0; t < 6; t++)
						if (gt == 0 && gmatch[t]) gt = 3'(t + 1);
					cur_slot = found;
					emit(KIND_RECORD, 0, SCHEME_GPT, cur_slot, st_sec, en_sec - st_sec + 1,
						0, gt, 0);
					found++;
				end
			end
		end else if (p >= 56 && p < 128) begin
			if (((p - 56) % 2) == 0) begin
				lowb = b;
			end else if (!nend) begin
				c = {b, lowb};
				if (c == 0 || nlen + 1 >= NAME_LIMIT) begin
					nend = 1'b1;
				end else begin
					emit(KIND_NAME, 0, SCHEME_NONE, cur_slot, 0, 0, 0, 0,
						c < 16'h80 ? c[6:0] : CHAR_SUB);
					nlen++;
				end
			end
		end
	endfunction

	function automatic void mbr_byte(int o, logic [7:0] b);
		int e, f;
		if (o >= MBR_TABLE_START && o < MBR_TABLE_END) begin
			e = (o - MBR_TABLE_START) >> 4;
			f = (o - MBR_TABLE_START) & 15;
			if (f == 4) begin
				mtype[e] = b;
				if (b == TYPE_PROTECTIVE) prot = 1'b1;
			end else if (f >= 8 && f < 12) begin
				mstart[e][8*(f-8) +: 8] = b;
			end else if (f >= 12) begin
				mcount[e][8*(f-12) +: 8] = b;
			end
		end else if (o == SIG_LOW_OFS) begin
			sig_low_seen = (b == SIG_LOW);
		end else if (o == LAST_OFS) begin
			if (!(sig_low_seen && b == SIG_HIGH)) begin
				emit(KIND_DONE, 0, SCHEME_NONE, 0, 0, 0, 0, 0, 0);
				ph = PH_IDLE;
			end else if (prot) begin
				ph = PH_HDR; hdr_good = 1'b1; arr_lba = 0; etotal = 0; size_fld = 0;
				emit(KIND_READ, 1, SCHEME_NONE, 0, 0, 0, 0, 0, 0);
			end else begin
				report_mbr_entries();
			end
		end
	endfunction

	function automatic void header_byte(int o, logic [7:0] b);
		if (o < HDR_SIG_LEN) begin
			if (b != HDR_SIG[o]) hdr_good = 1'b0;
		end else if (o >= HDR_ARRAY_OFS && o < HDR_TOTAL_OFS) begin
			arr_lba[8*(o-HDR_ARRAY_OFS) +: 8] = b;
		end else if (o >= HDR_TOTAL_OFS && o < HDR_SIZE_OFS) begin
			etotal[8*(o-HDR_TOTAL_OFS) +: 8] = b;
		end else if (o >= HDR_SIZE_OFS && o < HDR_SIZE_END) begin
			size_fld[8*(o-HDR_SIZE_OFS) +: 8] = b;
		end else if (o == LAST_OFS) begin
			if (hdr_good && size_fld >= ENTRY_MIN && size_fld <= ENTRY_MAX) begin
				ebytes = size_fld; sreads = 0; found = 0;
				if (etotal == 0) begin
					emit(KIND_DONE, 0, SCHEME_GPT, 0, 0, 0, 0, 0, 0);
					ph = PH_IDLE;
				end else begin
					ph = PH_ARR; epos = 0; ent_num = 0;
					emit(KIND_READ, arr_lba, SCHEME_NONE, 0, 0, 0, 0, 0, 0);
				end
			end else begin
				report_mbr_entries();
			end
		end
	endfunction

	function automatic void array_byte(int o, logic [7:0] b);
		logic [63:0] per, base;
		per = 512 / ebytes;
		base = 64'(sreads) * per;
		if (ent_num < per && base + ent_num < 64'(etotal)) entry_byte(epos, b);
		epos++;
		if (epos >= ebytes) begin
			epos = 0;
			ent_num++;
		end
		if (o == LAST_OFS) begin
			sreads++;
			base = 64'(sreads) * per;
			if (base < 64'(etotal) && found < MAX_PART) begin
				epos = 0; ent_num = 0;
				emit(KIND_READ, arr_lba + 64'(sreads), SCHEME_NONE, 0, 0, 0, 0, 0, 0);
			end else begin
				emit(KIND_DONE, 0, SCHEME_GPT, 0, 0, 0, 0, 0, 0);
				ph = PH_IDLE;
			end
		end
	endfunction

	function automatic void predict_scan_step(logic [1:0] cmd, logic [1:0] drv, logic [7:0] b);
		step_results.delete();
		if (cmd == CMD_START) begin
			sdrv = drv; ph = PH_MBR; boff = 0; sig_low_seen = 1'b0; prot = 1'b0; found = 0;
			emit(KIND_READ, 0, SCHEME_NONE, 0, 0, 0, 0, 0, 0);
		end else if (cmd == CMD_BYTE && ph != PH_IDLE) begin
			case (ph)
				PH_MBR: mbr_byte(boff, b);
				PH_HDR: header_byte(boff, b);
				default: array_byte(boff, b);
			endcase
			boff = boff + 1;
		end else if (cmd == CMD_FAIL && ph != PH_IDLE) begin
			if (ph == PH_MBR) begin
				emit(KIND_DONE, 0, SCHEME_NONE, 0, 0, 0, 0, 0, 0);
				ph = PH_IDLE;
			end else if (ph == PH_HDR) begin
				report_mbr_entries();
			end else begin
				emit(KIND_DONE, 0, SCHEME_GPT, 0, 0, 0, 0, 0, 0);
				ph = PH_IDLE;
			end
			boff = 0;
		end
		if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
		foreach (step_results[i]) pending_results.push_back(step_results[i]);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("ERROR at %0t: %s is %h, expected %h", $time, what, got, want);
		err_count++;
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		scan_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, kind", 64'(m_tuser), 0);
			end else begin
				e = pending_results.pop_front();
				check_field("kind", 64'(m_tuser), 64'(e.kind));
				check_field("last", 64'(m_tlast), 64'(e.last));
				check_field("read_drive", 64'(m_tdata[1:0]), 64'(e.drv));
				check_field("read_lba", m_tdata[65:2], e.lba);
				check_field("scheme", 64'(m_tdata[67:66]), 64'(e.scheme));
				check_field("part_index", 64'(m_tdata[71:68]), 64'(e.idx));
				check_field("part_first", m_tdata[135:72], e.ls);
				check_field("part_size", m_tdata[199:136], e.lc);
				check_field("legacy_type", 64'(m_tdata[207:200]), 64'(e.mt));
				check_field("gpt_type", 64'(m_tdata[210:208]), 64'(e.gt));
				check_field("name_char", 64'(m_tdata[217:211]), 64'(e.ch));
				check_field("padding", 64'(m_tdata[223:218]), 0);
			end
		end
	end

	always @(posedge clk) m_tready <= steady || ($urandom_range(99) >= 36);

	task automatic send(logic [1:0] cmd, logic [1:0] drv, logic [7:0] b);
		if (!steady) begin
			while ($urandom_range(99) < 36) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'b0, b, drv};
		do @(posedge clk); while (!s_tready);
		predict_scan_step(cmd, drv, b);
	endtask

	task automatic send_sector(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(63) == 0)
				send(CMD_NONE, 2'($urandom_range(3)), 8'($urandom_range(255)));
			send(CMD_BYTE, 2'($urandom_range(3)), sec[i]);
		end
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 64'($urandom_range(4095));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void fill_random();
		foreach (sec[i]) sec[i] = 8'($urandom_range(255));
	endfunction

	function automatic void build_mbr();
		int r, pe;
		fill_random();
		pe = $urandom_range(3);
		for (int e = 0; e < 4; e++) begin
			r = $urandom_range(5);
			sec[446 + 16*e + 4] = (r == 0) ? 8'h00 : 8'($urandom_range(1, 255));
			if (mbr_extreme) begin
				for (int k = 0; k < 4; k++) begin
					sec[446 + 16*e + 8 + k] = (e % 2) ? 8'hFF : 8'h00;
					sec[446 + 16*e + 12 + k] = 8'hFF;
				end
			end else if ($urandom_range(5) == 0) begin
				for (int k = 0; k < 4; k++) sec[446 + 16*e + 12 + k] = 8'h00;
			end
		end
		if ($urandom_range(4) != 0) sec[446 + 16*pe + 4] = TYPE_PROTECTIVE;
		sec[510] = SIG_LOW;
		sec[511] = SIG_HIGH;
	endfunction

	function automatic void build_header(logic [63:0] alba, logic [31:0] total,
			logic [31:0] size, bit sig_ok);
		fill_random();
		for (int i = 0; i < 8; i++) sec[i] = HDR_SIG[i];
		if (!sig_ok) sec[$urandom_range(7)] ^= 8'(1 << $urandom_range(7));
		for (int i = 0; i < 8; i++) sec[72 + i] = alba[8*i +: 8];
		for (int i = 0; i < 4; i++) begin
			sec[80 + i] = total[8*i +: 8];
			sec[84 + i] = size[8*i +: 8];
		end
	endfunction

	function automatic void build_entry(int ofs);
		int gsel, len, r;
		logic [63:0] st, en;
		gsel = (gsel_plan.size() > 0) ? gsel_plan.pop_front() : $urandom_range(9);
		for (int i = 0; i < 16; i++) begin
			if (gsel == 0) sec[ofs+i] = 8'h00;
			else if (gsel <= 6) sec[ofs+i] = KNOWN_GUID[gsel-1][i];
			else if (gsel == 7) sec[ofs+i] = KNOWN_GUID[(ofs / 128) % 6][i];
		end
		// A known type with one byte spoilt must not match.
		if (gsel == 7) sec[ofs + $urandom_range(15)] ^= 8'h01;
		st = rand64();
		en = ($urandom_range(3) == 0) ? rand64() : st + 64'($urandom_range(100000));
		for (int i = 0; i < 8; i++) begin
			sec[ofs+32+i] = st[8*i +: 8];
			sec[ofs+40+i] = en[8*i +: 8];
		end
		len = ($urandom_range(3) == 0) ? 36 : $urandom_range(36);
		for (int u = 0; u < 36; u++) begin
			if (u < len) begin
				r = $urandom_range(9);
				if (r == 0) begin
					sec[ofs+56+2*u] = 8'($urandom_range(255));
					sec[ofs+57+2*u] = 8'($urandom_range(1, 255));
				end else begin
					sec[ofs+56+2*u] = (r == 1) ? 8'($urandom_range(128, 255))
						: 8'($urandom_range(1, 127));
					sec[ofs+57+2*u] = 8'h00;
				end
			end else if (u == len) begin
				sec[ofs+56+2*u] = 8'h00;
				sec[ofs+57+2*u] = 8'h00;
			end
		end
	endfunction

	function automatic void build_array();
		logic [63:0] per, base;
		fill_random();
		per = 512 / ebytes;
		base = 64'(sreads) * per;
		for (int j = 0; j < per; j++)
			if (base + j < 64'(etotal)) build_entry(j * ebytes);
	endfunction

	// abort: 0 none, 1 read failure at sector abort_at, 2 restart inside that sector.
	task automatic run_scan(logic [1:0] drv, bit sig_ok, bit hdr_ok, logic [31:0] size,
			logic [31:0] total, logic [63:0] alba, int abort, int abort_at);
		int k;
		k = 0;
		scans_run++;
		send(CMD_START, drv, 8'($urandom_range(255)));
		while (ph != PH_IDLE && k < 64) begin
			case (ph)
				PH_MBR: begin
					build_mbr();
					if (!sig_ok) begin
						if ($urandom_range(1)) sec[510] = 8'($urandom_range(0, 84));
						else sec[511] = 8'($urandom_range(171, 255));
					end
				end
				PH_HDR: build_header(alba, total, size, hdr_ok);
				default: build_array();
			endcase
			if (abort == 1 && k == abort_at) begin
				send(CMD_FAIL, 2'($urandom_range(3)), 8'($urandom_range(255)));
			end else if (abort == 2 && k == abort_at) begin
				send_sector($urandom_range(511));
				send(CMD_START, 2'($urandom_range(3)), 8'($urandom_range(255)));
			end else begin
				send_sector(512);
			end
			k++;
		end
		if (ph != PH_IDLE) send(CMD_FAIL, drv, 8'h00);
	endtask

	task automatic test_ignored_items();
		send(CMD_BYTE, 2'd3, 8'hFF);
		send(CMD_FAIL, 2'd0, 8'h00);
		send(CMD_NONE, 2'd3, 8'hAA);
		send(CMD_NONE, 2'd0, 8'h55);
	endtask

	task automatic test_mbr_report();
		mbr_extreme = 1'b1;
		run_scan(2'd3, 1, 1, 128, 4, 2, 0, 0);
		mbr_extreme = 1'b0;
		run_scan(2'd0, 1, 1, 128, 4, 2, 0, 0);
	endtask

	task automatic test_bad_signature();
		run_scan(2'd1, 0, 1, 128, 4, 2, 0, 0);
		run_scan(2'd2, 1, 1, 128, 4, 2, 1, 0);
	endtask

	task automatic test_restart();
		run_scan(2'd1, 1, 1, 128, 8, 2, 2, 0);
		run_scan(2'd2, 1, 1, 128, 8, 2, 2, 2);
	endtask

	task automatic test_gpt_types();
		gsel_plan = '{1, 2, 3, 4, 5, 6, 0, 7, 8};
		run_scan(2'd2, 1, 1, 128, 9, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0);
	endtask

	task automatic test_gpt_fallbacks();
		run_scan(2'd0, 1, 0, 128, 4, 2, 0, 0);
		run_scan(2'd1, 1, 1, 127, 4, 2, 0, 0);
		run_scan(2'd2, 1, 1, 513, 4, 2, 0, 0);
		run_scan(2'd3, 1, 1, 128, 4, 2, 1, 1);
		run_scan(2'd0, 1, 1, 128, 0, 2, 0, 0);
		run_scan(2'd1, 1, 1, 128, 12, 2, 1, 3);
	endtask

	task automatic test_partition_limit();
		repeat (40) gsel_plan.push_back($urandom_range(1, 6));
		run_scan(2'd3, 1, 1, 128, 40, 34, 0, 0);
		gsel_plan.delete();
		run_scan(2'd2, 1, 1, 512, 3, 34, 0, 0);
		run_scan(2'd1, 1, 1, 200, 5, 34, 0, 0);
		run_scan(2'd0, 1, 1, 256, 32'hFFFF_FFFF, 34, 0, 0);
	endtask

	task automatic test_random_scans(int count);
		logic [31:0] size, total;
		int r;
		for (int n = 0; n < count; n++) begin
			steady = (n == count / 2);
			r = $urandom_range(11);
			size = (r < 6) ? 128 : (r == 6) ? 256 : (r == 7) ? 512 : (r == 8) ? 200
				: (r == 9) ? 32'($urandom_range(129, 511)) : $urandom;
			r = $urandom_range(15);
			total = (r == 0) ? 0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 24));
			r = $urandom_range(19);
			run_scan(2'($urandom_range(3)), $urandom_range(9) != 0, $urandom_range(6) != 0,
				size, total, rand64(), (r < 14) ? 0 : (r < 17) ? 1 : 2, $urandom_range(3));
			if ($urandom_range(3) == 0) test_ignored_items();
		end
		steady = 1'b0;
	endtask

	initial begin
		ph = PH_IDLE; sdrv = 0; boff = 0; prot = 0; hdr_good = 0; sig_low_seen = 0;
		arr_lba = 0; st_sec = 0; en_sec = 0; etotal = 0; ebytes = 0; sreads = 0;
		size_fld = 0; ent_num = 0; epos = 0; found = 0; cur_slot = 0; nlen = 0;
		gzero = 1; gmatch = '1; nend = 0; lowb = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_items();
		test_mbr_report();
		test_bad_signature();
		test_restart();
		test_gpt_types();
		test_gpt_fallbacks();
		test_partition_limit();
		test_random_scans(16);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d scans (MBR, GPT, fallbacks, failures, restarts, limits);",
			scans_run);
		$display("%0d results compared, %0d mismatches.", results_checked, err_count);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#500_000_000;
		$display("Timed out with %0d results outstanding.", pending_results.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* partition_table_parser.f */
rtl/core/ptp_pkg.sv
rtl/core/ptp_core.sv
rtl/core/ptp_emit.sv
rtl/core/partition_table_parser.sv
test/tb.sv
